### rtl/square_wave_tone_timer_assert.svh
// Assertion macros for the tone timer.
`ifndef SQUARE_WAVE_TONE_TIMER_ASSERT_SVH
`define SQUARE_WAVE_TONE_TIMER_ASSERT_SVH

// Same-cycle implication.
`define SWTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swtt assertion failed");

// Next-cycle implication.
`define SWTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swtt assertion failed");

`endif

### rtl/swtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swtt_pkg;

  localparam int unsigned LevelW  = 11;
  localparam int unsigned FreqW   = 16;
  localparam int unsigned DurW    = 16;
  localparam int unsigned HalfW   = 19;
  localparam int unsigned TickW   = 19;
  localparam int unsigned LeftW   = 24;
  localparam int unsigned ProdW   = 32;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned OutW    = 16;

  // product / 500 as (product * ceil(2^37 / 500)) >> 37, exact for any 32-bit product
  localparam int unsigned RcpW     = 61;
  localparam int unsigned RcpShift = 37;
  localparam logic [28:0] Recip500 = 29'd274877907;

  localparam logic [LevelW-1:0] LevelMax     = 11'd1024;
  localparam logic [LevelW-1:0] VolumeRst    = 11'd512;
  localparam logic [FreqW-1:0]  MsPerHalfDiv = 16'd500;
  localparam logic [ProdW-1:0]  HalfPeriodNum = 32'd500000;

  localparam logic [1:0] AddrVolume = 2'd0;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LDH,
    ST_DIVH,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic mul;
    logic div_load_h;
    logic div_step;
    logic latch_n;
    logic commit;
  } swtt_ctl_t;

  typedef struct packed {
    logic start_tone;
    logic div_last;
    logic out_free;
  } swtt_sts_t;

endpackage

`default_nettype wire

### rtl/swtt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module swtt_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  swtt_pkg::swtt_sts_t  sts_i,
  output swtt_pkg::swtt_ctl_t  ctl_o
);

  swtt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= swtt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      swtt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          state_d = sts_i.start_tone ? swtt_pkg::ST_MUL : swtt_pkg::ST_COMMIT;
        end
      end
      swtt_pkg::ST_MUL: begin
        ctl_o.mul = 1'b1;
        state_d   = swtt_pkg::ST_LDH;
      end
      swtt_pkg::ST_LDH: begin
        ctl_o.latch_n    = 1'b1;
        ctl_o.div_load_h = 1'b1;
        state_d          = swtt_pkg::ST_DIVH;
      end
      swtt_pkg::ST_DIVH: begin
        ctl_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = swtt_pkg::ST_COMMIT;
      end
      swtt_pkg::ST_COMMIT: begin
        // wait for the output slot
        if (sts_i.out_free) begin
          ctl_o.commit = 1'b1;
          state_d      = swtt_pkg::ST_IDLE;
        end
      end
      default: state_d = swtt_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/swtt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module swtt_dp (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire  [1:0]                           in_cmd_i,
  input  wire  [swtt_pkg::FreqW-1:0]           in_freq_i,
  input  wire  [swtt_pkg::DurW-1:0]            in_dur_i,
  input  wire  [swtt_pkg::LevelW-1:0]          volume_i,
  input  swtt_pkg::swtt_ctl_t                  ctl_i,
  output swtt_pkg::swtt_sts_t                  sts_o,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic [swtt_pkg::OutW-1:0]            out_data_o
);

  // latched item
  swtt_pkg::cmd_e                cmd_q;
  logic [swtt_pkg::FreqW-1:0]    freq_q;
  logic [swtt_pkg::DurW-1:0]     dur_q;
  logic                          tone_q;
  logic [swtt_pkg::ProdW-1:0]    prod_q;
  logic [swtt_pkg::LeftW-1:0]    n_q;

  // half period divider, one quotient bit per cycle
  logic [swtt_pkg::FreqW-1:0]    divisor_q;
  logic [swtt_pkg::ProdW-1:0]    quot_q;
  logic [swtt_pkg::FreqW-1:0]    rem_q;
  logic [swtt_pkg::DivCntW-1:0]  cnt_q;
  logic [swtt_pkg::FreqW:0]      trial;
  logic [swtt_pkg::FreqW:0]      diff;
  logic                          ge;

  // tone state
  logic [swtt_pkg::HalfW-1:0]    half_q, half_d;
  logic [swtt_pkg::TickW-1:0]    tick_q, tick_d, tick_inc;
  logic [swtt_pkg::LeftW-1:0]    left_q, left_d, left_dec;
  logic                          lvl_q, lvl_d;
  logic                          play_q, play_d;
  logic                          amp_q, amp_d;

  logic                          out_valid_q;
  logic [swtt_pkg::OutW-1:0]     out_data_q;
  logic [swtt_pkg::LevelW-1:0]   eff_level;
  logic [swtt_pkg::LevelW-1:0]   pwm_d;
  logic [swtt_pkg::RcpW-1:0]     rcp_prod;
  logic [swtt_pkg::LeftW-1:0]    n_quot;
  logic [swtt_pkg::LeftW-1:0]    n_calc;

  assign eff_level = (volume_i > swtt_pkg::LevelMax) ? swtt_pkg::LevelMax : volume_i;

  assign sts_o.start_tone = (in_cmd_i == swtt_pkg::CMD_PLAY) && (in_freq_i != '0) &&
                            (volume_i != '0);
  assign sts_o.div_last   = (cnt_q == '1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign trial = {rem_q, quot_q[swtt_pkg::ProdW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = (trial >= {1'b0, divisor_q});

  // half period count: product / 500 by reciprocal multiply, always fits 24 bits
  assign rcp_prod = prod_q * swtt_pkg::Recip500;
  assign n_quot   = rcp_prod[swtt_pkg::RcpShift +: swtt_pkg::LeftW];
  assign n_calc   = (dur_q == '0) ? '0 :
                    (n_quot == '0) ? {{(swtt_pkg::LeftW-1){1'b0}}, 1'b1} : n_quot;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      cmd_q  <= swtt_pkg::cmd_e'(in_cmd_i);
      freq_q <= in_freq_i;
      dur_q  <= in_dur_i;
      tone_q <= sts_o.start_tone;
    end
    if (ctl_i.mul) prod_q <= freq_q * dur_q;
    if (ctl_i.latch_n) n_q <= n_calc;
    if (ctl_i.div_load_h) begin
      divisor_q <= freq_q;
      quot_q    <= swtt_pkg::HalfPeriodNum;
      rem_q     <= '0;
    end else if (ctl_i.div_step) begin
      quot_q <= {quot_q[swtt_pkg::ProdW-2:0], ge};
      rem_q  <= ge ? diff[swtt_pkg::FreqW-1:0] : trial[swtt_pkg::FreqW-1:0];
    end
    if (ctl_i.commit) out_data_q <= {3'b000, play_d, amp_d, pwm_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      half_q      <= '0;
      tick_q      <= '0;
      left_q      <= '0;
      lvl_q       <= 1'b0;
      play_q      <= 1'b0;
      amp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.div_load_h) begin
        cnt_q <= '0;
      end else if (ctl_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (ctl_i.commit) begin
        half_q <= half_d;
        tick_q <= tick_d;
        left_q <= left_d;
        lvl_q  <= lvl_d;
        play_q <= play_d;
        amp_q  <= amp_d;
      end
      if (ctl_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign tick_inc = tick_q + 1'b1;
  assign left_dec = left_q - 1'b1;

  // state after the latched item
  always_comb begin
    half_d = half_q;
    tick_d = tick_q;
    left_d = left_q;
    lvl_d  = lvl_q;
    play_d = play_q;
    amp_d  = amp_q;
    case (cmd_q)
      swtt_pkg::CMD_PLAY: begin
        tick_d = '0;
        lvl_d  = 1'b0;
        play_d = 1'b0;
        amp_d  = 1'b0;
        if (tone_q) begin
          left_d = n_q;
          half_d = quot_q[swtt_pkg::HalfW-1:0];
          lvl_d  = 1'b1;
          play_d = 1'b1;
          amp_d  = 1'b1;
        end
      end
      swtt_pkg::CMD_STOP: begin
        tick_d = '0;
        lvl_d  = 1'b0;
        play_d = 1'b0;
        amp_d  = 1'b0;
      end
      swtt_pkg::CMD_TICK: begin
        if (play_q) begin
          tick_d = tick_inc;
          if (tick_inc >= half_q) begin
            tick_d = '0;
            if (left_q != '0) begin
              left_d = left_dec;
              if (left_dec == '0) begin
                lvl_d  = 1'b0;
                play_d = 1'b0;
                amp_d  = 1'b0;
              end else begin
                lvl_d = !lvl_q;
              end
            end else begin
              lvl_d = !lvl_q;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign pwm_d       = (play_d && lvl_d) ? eff_level : '0;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/square_wave_tone_timer.sv
// Square wave tone timer. Input beats carry a command in s_axis_tuser_i (tick, play, stop)
// and the play arguments in s_axis_tdata_i; every input beat yields exactly one output beat
// with pwm level, amplifier enable and tone-active flag after that command. Ticks, stops
// and plays that turn out to be rests go from accept straight to commit. A sounding play
// goes through accept, the 16x16 multiply, a step that divides the product by 500 with a
// reciprocal multiply and loads the divider, the one-bit-per-cycle restoring divider for
// the half period, then commit. One item is worked on at a time; a finished beat waits in
// the output register while the next item is accepted, and commit stalls only if that
// register is still full. The volume register is written over APB at address 0; the user
// must write it only while the block is idle, the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "square_wave_tone_timer_assert.svh"

module square_wave_tone_timer (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [31:0] s_axis_tdata_i,   // [15:0] freq_hz, [31:16] duration_ms
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] cmd
  // result stream
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [10:0] pwm_level, [11] amp_enable,
                                        // [12] tone_active, [15:13] zero
  // config port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [1:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  swtt_pkg::swtt_ctl_t ctl;
  swtt_pkg::swtt_sts_t sts;

  logic [swtt_pkg::LevelW-1:0] volume_q;
  logic                        cfg_wr;

  // assertion helpers
  logic                        in_fire;
  logic                        out_sounding;
  logic                        out_on;

  // APB: zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == swtt_pkg::AddrVolume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= swtt_pkg::VolumeRst;
    end else if (cfg_wr) begin
      volume_q <= pwdata[swtt_pkg::LevelW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == swtt_pkg::AddrVolume) begin
      prdata = {{(32 - swtt_pkg::LevelW){1'b0}}, volume_q};
    end
  end

  // sequencer: accept, multiply, divide, commit
  swtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // item latch, multipliers, divider, tone state, output register
  swtt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (s_axis_tuser_i),
    .in_freq_i    (s_axis_tdata_i[15:0]),
    .in_dur_i     (s_axis_tdata_i[31:16]),
    .volume_i     (volume_q),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o)
  );

  assign in_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign out_sounding = m_axis_tvalid_o && (m_axis_tdata_o[10:0] != '0);
  assign out_on       = m_axis_tdata_o[12] && m_axis_tdata_o[11];

  // one item in flight: no accept right after an accept
  `SWTT_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_fire, !s_axis_tready_o)
  // results never overwrite a beat still waiting
  `SWTT_ASSERT_IMP(a_commit_free, clk_i, rst_ni, ctl.commit, !m_axis_tvalid_o || m_axis_tready_i)
  // sound only while a tone is playing
  `SWTT_ASSERT_IMP(a_pwm_active, clk_i, rst_ni, out_sounding, out_on)

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 80;   // longer than a sounding play takes
  localparam int unsigned RandomBeats = 770;

  // expected output beat
  typedef struct {
    logic [swtt_pkg::LevelW-1:0] pwm;
    logic                        amp;
    logic                        active;
  } speaker_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // input stream
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;    // [15:0] freq_hz, [31:16] duration_ms
  logic [1:0]  s_user = swtt_pkg::CMD_TICK;  // [1:0] cmd

  // result stream
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;         // [10:0] pwm_level, [11] amp_enable, [12] tone_active

  // config port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = swtt_pkg::AddrVolume;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  square_wave_tone_timer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Shadow of the tone generator: its register and its timing state.
  logic [swtt_pkg::LevelW-1:0] sh_volume = swtt_pkg::VolumeRst;
  logic [swtt_pkg::HalfW-1:0]  sh_half = '0;
  logic [swtt_pkg::TickW-1:0]  sh_ticks = '0;
  logic [swtt_pkg::LeftW-1:0]  sh_left = '0;
  logic                        sh_high = 1'b0;
  logic                        sh_playing = 1'b0;
  logic                        sh_amp = 1'b0;

  speaker_t speaker_q[$];    // speaker states still to come out of the block

  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned plays_sounded = 0;
  int unsigned level_writes = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;
  bit          idle_on = 1'b1;
  int          out_stall = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Steps the shadow state by one command and returns what the speaker pins show after it.
  function automatic speaker_t next_speaker_state(swtt_pkg::cmd_e cmd,
                                                  logic [swtt_pkg::FreqW-1:0] freq,
                                                  logic [swtt_pkg::DurW-1:0] dur);
    logic [swtt_pkg::ProdW-1:0]  prod;
    logic [swtt_pkg::ProdW-1:0]  halves;
    logic [swtt_pkg::ProdW-1:0]  half;
    logic [swtt_pkg::LevelW-1:0] lvl;
    speaker_t                    res;
    lvl = (sh_volume > swtt_pkg::LevelMax) ? swtt_pkg::LevelMax : sh_volume;
    case (cmd)
      swtt_pkg::CMD_PLAY: begin
        // a new play always cuts the running tone first
        sh_playing = 1'b0;
        sh_amp = 1'b0;
        sh_high = 1'b0;
        sh_ticks = '0;
        if (freq != '0 && lvl != '0) begin
          halves = '0;
          if (dur != '0) begin
            prod = swtt_pkg::ProdW'(freq) * swtt_pkg::ProdW'(dur);
            halves = prod / swtt_pkg::ProdW'(swtt_pkg::MsPerHalfDiv);
            if (halves == '0) halves = swtt_pkg::ProdW'(1);
          end
          half = swtt_pkg::HalfPeriodNum / swtt_pkg::ProdW'(freq);
          sh_left = halves[swtt_pkg::LeftW-1:0];
          sh_half = half[swtt_pkg::HalfW-1:0];
          sh_high = 1'b1;
          sh_amp = 1'b1;
          sh_playing = 1'b1;
        end
      end
      swtt_pkg::CMD_STOP: begin
        sh_playing = 1'b0;
        sh_amp = 1'b0;
        sh_high = 1'b0;
        sh_ticks = '0;
      end
      swtt_pkg::CMD_TICK: begin
        if (sh_playing) begin
          sh_ticks = sh_ticks + 1'b1;
          if (sh_ticks >= sh_half) begin
            sh_ticks = '0;
            if (sh_left != '0) begin
              sh_left = sh_left - 1'b1;
              if (sh_left == '0) begin
                // tone ran out
                sh_playing = 1'b0;
                sh_amp = 1'b0;
                sh_high = 1'b0;
              end else begin
                sh_high = ~sh_high;
              end
            end else begin
              sh_high = ~sh_high;
            end
          end
        end
      end
      default: ;
    endcase
    res.pwm = (sh_playing && sh_high) ? lvl : '0;
    res.amp = sh_amp;
    res.active = sh_playing;
    return res;
  endfunction

  // Result side: random backpressure and the field-by-field compare.
  always @(posedge clk_i) begin
    speaker_t want;
    if (rst_ni && m_valid && m_ready) begin
      beats_out++;
      if (speaker_q.size() == 0) begin
        $error("result beat with nothing expected: data %h", m_data);
        fails++;
      end else begin
        want = speaker_q.pop_front();
        if (m_data[10:0] !== want.pwm) begin
          $error("pwm_level: expected %0d, got %0d", want.pwm, m_data[10:0]);
          fails++;
        end
        if (m_data[11] !== want.amp) begin
          $error("amp_enable: expected %0d, got %0d", want.amp, m_data[11]);
          fails++;
        end
        if (m_data[12] !== want.active) begin
          $error("tone_active: expected %0d, got %0d", want.active, m_data[12]);
          fails++;
        end
      end
    end
    if (out_stall > 0) begin
      m_ready <= 1'b0;
      out_stall--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      m_ready <= 1'b0;
      out_stall = $urandom_range(1, 11) - 1;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Sends one beat; tvalid stays up afterwards so the next call can follow back to back.
  task automatic send_beat(swtt_pkg::cmd_e cmd, logic [swtt_pkg::FreqW-1:0] freq,
                           logic [swtt_pkg::DurW-1:0] dur);
    speaker_t want;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= cmd;
    s_data <= {dur, freq};
    do @(posedge clk_i); while (!s_ready);
    want = next_speaker_state(cmd, freq, dur);
    if (cmd == swtt_pkg::CMD_PLAY && want.active) plays_sounded++;
    speaker_q.push_back(want);
    beats_in++;
  endtask

  // Drop tvalid and wait until every result is out and the block has settled.
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (speaker_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write of the volume register followed by a read back.
  task automatic set_volume(logic [31:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= swtt_pkg::AddrVolume;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sh_volume = value[swtt_pkg::LevelW-1:0];
    level_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {21'b0, sh_volume}) begin
      $error("volume readback: expected %0d, got %0d", sh_volume, prdata);
      fails++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'd1024;
      3: return 32'd2047;
      4: return 32'd1025;
      5: return $urandom();   // upper bits are dropped by the register
      default: return $urandom_range(1, 1023);
    endcase
  endfunction

  // Commands with no tone running change nothing.
  task automatic test_idle_commands();
    send_beat(swtt_pkg::CMD_TICK, '0, '0);
    send_beat(swtt_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF);
    send_beat(swtt_pkg::CMD_STOP, 16'hFFFF, 16'hFFFF);
  endtask

  // Field extremes, toggling, play while playing, rest by frequency, endless tone, stop.
  task automatic test_play_cases();
    send_beat(swtt_pkg::CMD_PLAY, 16'hFFFF, 16'hFFFF);
    // half period of 7 ticks: toggles on the 7th
    repeat (7) send_beat(swtt_pkg::CMD_TICK, '0, '0);
    send_beat(swtt_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF);
    send_beat(swtt_pkg::CMD_PLAY, 16'd1, 16'd1);        // cuts the running tone
    send_beat(swtt_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
    send_beat(swtt_pkg::CMD_PLAY, 16'd0, 16'd100);      // rest
    send_beat(swtt_pkg::CMD_PLAY, 16'hFFFF, 16'd0);     // no end
    send_beat(swtt_pkg::CMD_STOP, '0, '0);
  endtask

  // Zero level as a rest, clamping above 1024, and a level change while a tone plays.
  task automatic test_level_edges();
    set_volume(32'd0);
    send_beat(swtt_pkg::CMD_PLAY, 16'd1000, 16'd5);
    set_volume(32'd2047);
    send_beat(swtt_pkg::CMD_PLAY, 16'hFFFF, 16'd0);
    send_beat(swtt_pkg::CMD_TICK, '0, '0);
    set_volume(32'd1024);
    send_beat(swtt_pkg::CMD_TICK, '0, '0);
    set_volume(32'd1);
    send_beat(swtt_pkg::CMD_STOP, '0, '0);
  endtask

  // Short tone whose count is floored to one half period; it must go silent on its own.
  task automatic test_tone_runout();
    set_volume(32'd512);
    send_beat(swtt_pkg::CMD_PLAY, 16'd499, 16'd1);      // 1 half period of 1002 ticks
    repeat (1005) send_beat(swtt_pkg::CMD_TICK, '0, '0);
  endtask

  // Mostly play-then-tick sequences with random content, plus stray beats and level changes.
  task automatic test_random_traffic();
    int unsigned                stop_at;
    int unsigned                run;
    logic [swtt_pkg::FreqW-1:0] freq;
    logic [swtt_pkg::DurW-1:0]  dur;
    stop_at = beats_in + RandomBeats;
    while (beats_in < stop_at) begin
      // quiet last stretch: no gaps on either side
      if (beats_in + 200 > stop_at) idle_on = 1'b0;
      case ($urandom_range(0, 19))
        0: set_volume(pick_level());
        1, 2, 3: send_beat(swtt_pkg::cmd_e'($urandom_range(0, 3)),
                           swtt_pkg::FreqW'($urandom()), swtt_pkg::DurW'($urandom()));
        default: begin
          case ($urandom_range(0, 9))
            0:       freq = '0;
            1, 2:    freq = swtt_pkg::FreqW'($urandom());
            // short half periods
            default: freq = swtt_pkg::FreqW'($urandom_range(20000, 65535));
          endcase
          case ($urandom_range(0, 3))
            0, 1:    dur = '0;
            2:       dur = swtt_pkg::DurW'($urandom_range(1, 4));
            default: dur = swtt_pkg::DurW'($urandom());
          endcase
          send_beat(swtt_pkg::CMD_PLAY, freq, dur);
          run = $urandom_range(4, 40);
          repeat (run) begin
            if ($urandom_range(0, 29) == 0)
              send_beat(swtt_pkg::cmd_e'($urandom_range(1, 3)),
                        swtt_pkg::FreqW'($urandom()), swtt_pkg::DurW'($urandom()));
            else
              send_beat(swtt_pkg::CMD_TICK,
                        swtt_pkg::FreqW'($urandom()), swtt_pkg::DurW'($urandom()));
          end
          if ($urandom_range(0, 3) == 0)
            send_beat(swtt_pkg::CMD_STOP,
                      swtt_pkg::FreqW'($urandom()), swtt_pkg::DurW'($urandom()));
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_commands();
    test_play_cases();
    test_level_edges();
    test_tone_runout();
    test_random_traffic();

    wait_drained();
    $display("sent %0d command beats (%0d sounding plays), checked %0d result beats",
             beats_in, plays_sounded, beats_out);
    $display("volume written %0d times, including 0, 1024 and 2047", level_writes);
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
